>>> src/i2cmw_pkg.sv
package i2cmw_pkg;

  // Job codes that travel from the front to the back
  localparam logic [2:0] OP_BYTE       = 3'd0;
  localparam logic [2:0] OP_NACK       = 3'd1;
  localparam logic [2:0] OP_ACK_CONT   = 3'd2;
  localparam logic [2:0] OP_ACK_HOLD   = 3'd3;
  localparam logic [2:0] OP_ACK_STOP   = 3'd4;
  localparam logic [2:0] OP_EMPTY_KEEP = 3'd5;
  localparam logic [2:0] OP_EMPTY_STOP = 3'd6;

  // Input item kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // Pin action indexes inside a byte job
  localparam logic [4:0] STEP_BITS_FIRST = 5'd2;
  localparam logic [4:0] STEP_BITS_LAST  = 5'd25;
  localparam logic [4:0] STEP_BYTE_LAST  = 5'd27;
  localparam logic [1:0] PHASE_LAST      = 2'd2;

  typedef struct packed {
    logic [2:0] op;
    logic       start;
    logic       scl0;
    logic [7:0] data;
  } job_t;

endpackage

>>> src/i2cmw_front.sv
module i2cmw_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        kind,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic              keep_bus,
  input  logic              sda_sample,
  output logic              push,
  output i2cmw_pkg::job_t   job
);

  logic transaction_open, transaction_open_next;
  logic awaiting_ack, awaiting_ack_next;
  logic pending_last, pending_last_next;
  logic pending_keep_bus, pending_keep_bus_next;
  logic job_valid;

  // Classify the item and update the message state
  always_comb begin
    transaction_open_next = transaction_open;
    awaiting_ack_next     = awaiting_ack;
    pending_last_next     = pending_last;
    pending_keep_bus_next = pending_keep_bus;
    job_valid             = 1'b0;
    job.op                = i2cmw_pkg::OP_BYTE;
    job.start             = 1'b0;
    job.scl0              = ~transaction_open;
    job.data              = data_byte;
    unique case (kind)
      i2cmw_pkg::KIND_BYTE: begin
        if (!awaiting_ack) begin
          job_valid             = 1'b1;
          job.start             = ~transaction_open | pending_last;
          transaction_open_next = 1'b1;
          awaiting_ack_next     = 1'b1;
          pending_last_next     = last_byte;
          pending_keep_bus_next = keep_bus;
        end
      end
      i2cmw_pkg::KIND_ACK: begin
        if (awaiting_ack) begin
          job_valid         = 1'b1;
          awaiting_ack_next = 1'b0;
          if (sda_sample) begin
            job.op                = i2cmw_pkg::OP_NACK;
            transaction_open_next = 1'b0;
            pending_last_next     = 1'b0;
            pending_keep_bus_next = 1'b0;
          end else if (!pending_last) begin
            job.op = i2cmw_pkg::OP_ACK_CONT;
          end else if (pending_keep_bus) begin
            job.op = i2cmw_pkg::OP_ACK_HOLD;
          end else begin
            job.op                = i2cmw_pkg::OP_ACK_STOP;
            transaction_open_next = 1'b0;
            pending_last_next     = 1'b0;
            pending_keep_bus_next = 1'b0;
          end
        end
      end
      i2cmw_pkg::KIND_EMPTY: begin
        if (!awaiting_ack) begin
          job_valid = 1'b1;
          job.start = 1'b1;
          if (keep_bus) begin
            job.op                = i2cmw_pkg::OP_EMPTY_KEEP;
            transaction_open_next = 1'b1;
            pending_last_next     = 1'b1;
            pending_keep_bus_next = 1'b1;
          end else begin
            job.op                = i2cmw_pkg::OP_EMPTY_STOP;
            transaction_open_next = 1'b0;
            pending_last_next     = 1'b0;
            pending_keep_bus_next = 1'b0;
          end
        end
      end
      default: begin
        job_valid = 1'b0;
      end
    endcase
  end

  assign push = accept & job_valid;

  // Commit state only on accepted items
  always_ff @(posedge clk) begin
    if (rst) begin
      transaction_open <= 1'b0;
      awaiting_ack     <= 1'b0;
      pending_last     <= 1'b0;
      pending_keep_bus <= 1'b0;
    end else if (accept) begin
      transaction_open <= transaction_open_next;
      awaiting_ack     <= awaiting_ack_next;
      pending_last     <= pending_last_next;
      pending_keep_bus <= pending_keep_bus_next;
    end
  end

  a_ack_needs_open: assert property (@(posedge clk) disable iff (rst)
    awaiting_ack |-> transaction_open)
    else $error("acknowledge awaited with no open transaction");

  a_ignored_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (accept && !push) |=> $stable(awaiting_ack) && $stable(transaction_open))
    else $error("ignored item changed message state");

endmodule

>>> src/i2cmw_fifo.sv
module i2cmw_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  i2cmw_pkg::job_t   push_job,
  input  logic              pop,
  output logic              head_valid,
  output i2cmw_pkg::job_t   head_job,
  output logic              full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  i2cmw_pkg::job_t entries [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rptr];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  // Store the job at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("job pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue occupancy out of range");

endmodule

>>> src/i2cmw_back.sv
module i2cmw_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  i2cmw_pkg::job_t   head_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              scl_level,
  output logic              sda_level,
  output logic              done_res,
  output logic              nack,
  output logic              last_of_run
);

  logic [4:0] step;
  logic [4:0] eff;
  logic [2:0] bit_idx;
  logic [1:0] phase;
  logic       load;
  logic       act_scl, act_sda, act_done, act_nack, act_last;
  logic       cur_bit;
  logic       in_bits;

  // Skip the start actions of a byte that continues a message
  assign eff = (head_job.op == i2cmw_pkg::OP_BYTE && !head_job.start) ?
               step + i2cmw_pkg::STEP_BITS_FIRST : step;
  assign in_bits = (eff >= i2cmw_pkg::STEP_BITS_FIRST) &&
                   (eff <= i2cmw_pkg::STEP_BITS_LAST);
  assign cur_bit = head_job.data[3'd7 - bit_idx];
  assign load    = ~out_valid | ~out_stall;
  assign pop     = head_valid & load & act_last;

  // Decode the pin action for the current step
  always_comb begin
    act_scl  = 1'b1;
    act_sda  = 1'b1;
    act_done = 1'b0;
    act_nack = 1'b0;
    act_last = 1'b0;
    unique case (head_job.op)
      i2cmw_pkg::OP_BYTE: begin
        if (eff == 5'd0) begin
          act_scl = head_job.scl0;
          act_sda = 1'b0;
        end else if (eff == 5'd1) begin
          act_scl = 1'b0;
          act_sda = 1'b0;
        end else if (in_bits) begin
          act_scl = (phase == 2'd1);
          act_sda = cur_bit;
        end else begin
          act_scl  = (eff == i2cmw_pkg::STEP_BYTE_LAST);
          act_sda  = 1'b1;
          act_last = (eff == i2cmw_pkg::STEP_BYTE_LAST);
        end
      end
      i2cmw_pkg::OP_NACK: begin
        act_done = (eff == 5'd1);
        act_nack = (eff == 5'd1);
        act_last = (eff == 5'd1);
      end
      i2cmw_pkg::OP_ACK_CONT, i2cmw_pkg::OP_ACK_HOLD: begin
        act_scl  = (eff == 5'd0);
        act_sda  = 1'b0;
        act_done = (eff == 5'd1) && (head_job.op == i2cmw_pkg::OP_ACK_HOLD);
        act_last = (eff == 5'd1);
      end
      i2cmw_pkg::OP_ACK_STOP: begin
        act_scl  = (eff != 5'd1);
        act_sda  = (eff == 5'd3);
        act_done = (eff == 5'd3);
        act_last = (eff == 5'd3);
      end
      i2cmw_pkg::OP_EMPTY_KEEP: begin
        act_scl  = (eff == 5'd0) ? head_job.scl0 : 1'b0;
        act_sda  = 1'b0;
        act_done = (eff == 5'd1);
        act_last = (eff == 5'd1);
      end
      i2cmw_pkg::OP_EMPTY_STOP: begin
        act_scl  = (eff == 5'd0) ? head_job.scl0 : (eff != 5'd1);
        act_sda  = (eff == 5'd3);
        act_done = (eff == 5'd3);
        act_last = (eff == 5'd3);
      end
      default: begin
        act_last = 1'b1;
      end
    endcase
  end

  // Advance the step, bit and phase counters
  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= '0;
      bit_idx <= '0;
      phase   <= '0;
    end else if (head_valid && load) begin
      if (act_last) begin
        step    <= '0;
        bit_idx <= '0;
        phase   <= '0;
      end else begin
        step <= step + 1'b1;
        if (in_bits) begin
          if (phase == i2cmw_pkg::PHASE_LAST) begin
            phase   <= '0;
            bit_idx <= bit_idx + 1'b1;
          end else begin
            phase <= phase + 1'b1;
          end
        end
      end
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      scl_level   <= act_scl;
      sda_level   <= act_sda;
      done_res    <= act_done;
      nack        <= act_nack;
      last_of_run <= act_last;
    end
  end

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> last_of_run)
    else $error("status reported before the end of a run");

  a_nack_released: assert property (@(posedge clk) disable iff (rst)
    (out_valid && nack) |-> (done_res && scl_level && sda_level))
    else $error("nack reported with a line held low");

endmodule

>>> src/i2c_master_write_sequencer_core.sv
// The first pin action of an item passes through the job queue and then the output register
// before it is shown, when both are empty at the time the item is accepted.
// One pin action is shown per cycle while out_stall is low and a job is queued;
// an ignored item gives no job to the back end.
// The front accepts an item every cycle while the job queue (DEPTH entries) has room.
// Reset (rst, synchronous): no transaction open, queue and output emptied.
module i2c_master_write_sequencer_core #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       keep_bus,
  input  logic       sda_sample,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_level,
  output logic       sda_level,
  output logic       done_res,
  output logic       nack,
  output logic       last_of_run
);

  i2cmw_pkg::job_t push_job;
  i2cmw_pkg::job_t head_job;
  logic            push;
  logic            pop;
  logic            head_valid;
  logic            full;

  assign in_stall = full;

  i2cmw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_valid & ~in_stall),
    .kind       (kind),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .keep_bus   (keep_bus),
    .sda_sample (sda_sample),
    .push       (push),
    .job        (push_job)
  );

  i2cmw_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .full       (full)
  );

  i2cmw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .scl_level   (scl_level),
    .sda_level   (sda_level),
    .done_res    (done_res),
    .nack        (nack),
    .last_of_run (last_of_run)
  );

endmodule
